// ===== rtl/pfa_pkg.sv =====
package pfa_pkg;

  localparam int FRAMES_DEF         = 256;
  localparam int PROC_SLOTS_DEF     = 16;
  localparam int PAGES_PER_PROC_DEF = 64;

  localparam int PS_W    = 17;
  localparam int FIU_W   = 9;
  localparam int PID_W   = 32;
  localparam int DELTA_W = 21;
  localparam int FRAME_W = 8;
  localparam int ST_W    = 3;
  localparam int CNT_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_END    = 2'd1,
    ACT_RESIZE = 2'd2,
    ACT_NEXT   = 2'd3
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_PID  = 3'd1,
    ST_OOM     = 3'd2,
    ST_NO_SLOT = 3'd3,
    ST_NO_NEXT = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES    = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_DIV,
    S_END_RD,
    S_END_WAIT,
    S_GROW_SCAN,
    S_SHR_RD,
    S_SHR_WAIT,
    S_NEXT_RD,
    S_NEXT_WAIT,
    S_NEXT_HIT,
    S_NEXT_HIT_WAIT,
    S_DONE
  } state_t;

endpackage

// ===== rtl/pfa_div.sv =====
module pfa_div #(
  parameter int NW = 21,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW+1:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[NW-1]} - {2'b00, den_r};
    if (go) begin
      q_nxt   = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-1:0], q_r[NW-1]};
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// ===== rtl/paged_frame_allocator.sv =====
// Frame allocator with per-process page tables. A request is taken when start is high and
// busy low; busy then stays high until the single result appears for one cycle on out_valid,
// which the receiver cannot stall. Requests are run by one sequencer that walks one bitmap
// bit per cycle, or one page-table entry per read state and wait state: the slot lookup visits
// all PROC_SLOTS slots; a nonzero resize adds a bit-serial divide, then a bitmap scan over the
// whole grow, bounded by the configured frame limit, or a read and a wait per dropped page; end
// takes a read and a wait per page held; next takes a read and a wait per page examined, and
// S_NEXT_HIT and S_NEXT_HIT_WAIT on a hit. S_DONE closes every request, then the result beat.
// The page table is a single-port memory with registered read.
module paged_frame_allocator
  import pfa_pkg::*;
#(
  parameter int FRAMES         = FRAMES_DEF,
  parameter int PROC_SLOTS     = PROC_SLOTS_DEF,
  parameter int PAGES_PER_PROC = PAGES_PER_PROC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [pfa_pkg::PID_W-1:0]     in_pid,
  input  logic signed [pfa_pkg::DELTA_W-1:0] in_byte_delta,
  input  logic [pfa_pkg::FRAME_W-1:0]   in_current_frame,
  output logic                          out_valid,
  output logic [pfa_pkg::ST_W-1:0]      out_status,
  output logic [pfa_pkg::FRAME_W-1:0]   out_frame,
  output logic [pfa_pkg::CNT_W-1:0]     out_page_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCW = $clog2(FRAMES + 1);
  localparam int SW  = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
  localparam int SCW = $clog2(PROC_SLOTS + 1);
  localparam int PW  = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
  localparam int PCW = $clog2(PAGES_PER_PROC + 1);
  localparam int MD  = PROC_SLOTS * PAGES_PER_PROC;
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;

  state_t state_r, state_nxt;

  logic [PS_W-1:0]  page_size_r;
  logic [FIU_W-1:0] frames_cfg_r;

  logic [FRAMES-1:0]     frame_used_r, frame_used_nxt;
  logic [PROC_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [PID_W-1:0]      slot_pid_r [PROC_SLOTS];
  logic [PCW-1:0]        slot_pages_r [PROC_SLOTS];

  logic [FW-1:0] pt_mem [MD];
  logic [FW-1:0] pt_rd_r;
  logic          pt_we;
  logic [AW-1:0] pt_addr;
  logic [FW-1:0] pt_wdata;

  action_t            act_r, act_nxt;
  logic [PID_W-1:0]   pid_r, pid_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;

  logic [SCW-1:0] si_r, si_nxt;
  logic [SW-1:0]  hit_r, hit_nxt;
  logic           hit_ok_r, hit_ok_nxt;
  logic [SW-1:0]  free_r, free_nxt;
  logic           free_ok_r, free_ok_nxt;

  logic [PCW-1:0] pages_r, pages_nxt;
  logic [PCW-1:0] pi_r, pi_nxt;
  logic [DELTA_W-1:0] need_r, need_nxt;
  logic [FCW-1:0] fi_r, fi_nxt;

  logic [ST_W-1:0]    st_r, st_nxt;
  logic [FRAME_W-1:0] fr_r, fr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ov_r, ov_nxt;

  logic               div_go;
  logic [DELTA_W-1:0] div_num;
  logic [PS_W-1:0]    div_den;
  logic               div_done;
  logic [DELTA_W-1:0] div_q;

  logic [PS_W-1:0]    ps_eff;
  logic [FCW-1:0]     flimit;
  logic [FIU_W:0]     fcfg_ext;
  logic [DELTA_W-1:0] mag;
  logic [AW-1:0]      base;

  assign ps_eff   = (page_size_r == '0) ? PS_W'(1) : page_size_r;
  assign fcfg_ext = {1'b0, frames_cfg_r};
  assign mag      = DELTA_W'(0) - delta_r;
  assign base     = AW'(hit_r) * AW'(PAGES_PER_PROC);

  generate
    if (FCW > FIU_W + 1) begin : g_lim_w
      assign flimit = (FCW'(frames_cfg_r) < FCW'(FRAMES)) ? FCW'(frames_cfg_r) : FCW'(FRAMES);
    end else begin : g_lim_n
      assign flimit = (fcfg_ext < (FIU_W+1)'(FRAMES)) ? FCW'(fcfg_ext) : FCW'(FRAMES);
    end
  endgenerate

  pfa_div #(.NW(DELTA_W), .DW(PS_W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_addr] <= pt_wdata;
    pt_rd_r <= pt_mem[pt_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    pid_nxt        = pid_r;
    delta_nxt      = delta_r;
    cur_nxt        = cur_r;
    si_nxt         = si_r;
    hit_nxt        = hit_r;
    hit_ok_nxt     = hit_ok_r;
    free_nxt       = free_r;
    free_ok_nxt    = free_ok_r;
    pages_nxt      = pages_r;
    pi_nxt         = pi_r;
    need_nxt       = need_r;
    fi_nxt         = fi_r;
    st_nxt         = st_r;
    fr_nxt         = fr_r;
    cnt_nxt        = cnt_r;
    ov_nxt         = 1'b0;
    frame_used_nxt = frame_used_r;
    slot_valid_nxt = slot_valid_r;
    pt_we          = 1'b0;
    pt_addr        = base + AW'(pi_r);
    pt_wdata       = '0;
    div_go         = 1'b0;
    div_num        = delta_r[DELTA_W-1] ? mag : delta_r + DELTA_W'(ps_eff) - DELTA_W'(1);
    div_den        = ps_eff;

    unique case (state_r)
      S_IDLE: begin
        if (start && !ov_r) begin
          act_nxt     = action_t'(in_action);
          pid_nxt     = in_pid;
          delta_nxt   = in_byte_delta;
          cur_nxt     = in_current_frame;
          si_nxt      = '0;
          hit_ok_nxt  = 1'b0;
          free_ok_nxt = 1'b0;
          st_nxt      = ST_OK;
          fr_nxt      = '0;
          cnt_nxt     = '0;
          state_nxt   = S_FIND;
        end
      end
      S_FIND: begin
        if (slot_valid_r[si_r[SW-1:0]] && slot_pid_r[si_r[SW-1:0]] == pid_r && !hit_ok_r) begin
          hit_nxt    = si_r[SW-1:0];
          hit_ok_nxt = 1'b1;
        end
        if (!slot_valid_r[si_r[SW-1:0]] && !free_ok_r) begin
          free_nxt    = si_r[SW-1:0];
          free_ok_nxt = 1'b1;
        end
        si_nxt = si_r + 1'b1;
        if (si_r == SCW'(PROC_SLOTS - 1)) begin
          pages_nxt = slot_pages_r[hit_nxt];
          pi_nxt    = '0;
          if (act_r == ACT_CREATE) begin
            if (hit_ok_nxt) begin
              cnt_nxt = CNT_W'(slot_pages_r[hit_nxt]);
            end else if (!free_ok_nxt) begin
              st_nxt = ST_NO_SLOT;
            end else begin
              slot_valid_nxt[free_nxt] = 1'b1;
            end
            state_nxt = S_DONE;
          end else if (!hit_ok_nxt) begin
            st_nxt    = ST_NO_PID;
            state_nxt = S_DONE;
          end else begin
            unique case (act_r)
              ACT_END:    state_nxt = S_END_RD;
              ACT_RESIZE: begin
                if (delta_r == '0) begin
                  cnt_nxt   = CNT_W'(pages_nxt);
                  state_nxt = S_DONE;
                end else begin
                  div_go    = 1'b1;
                  state_nxt = S_DIV;
                end
              end
              default: begin
                st_nxt    = ST_NO_NEXT;
                cnt_nxt   = CNT_W'(pages_nxt);
                state_nxt = S_NEXT_RD;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          need_nxt = div_q;
          fi_nxt   = '0;
          if (delta_r[DELTA_W-1]) state_nxt = S_SHR_RD;
          else state_nxt = S_GROW_SCAN;
        end
      end
      S_END_RD: begin
        if (pi_r >= pages_r) begin
          slot_valid_nxt[hit_r] = 1'b0;
          pages_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_END_WAIT;
        end
      end
      S_END_WAIT: begin
        if (32'(pt_rd_r) < FRAMES) frame_used_nxt[pt_rd_r] = 1'b0;
        pi_nxt    = pi_r + 1'b1;
        pt_addr   = base + AW'(pi_nxt);
        state_nxt = S_END_RD;
      end
      S_GROW_SCAN: begin
        if (need_r == '0) begin
          cnt_nxt   = CNT_W'(pages_r);
          state_nxt = S_DONE;
        end else if (pages_r >= PCW'(PAGES_PER_PROC) || fi_r >= flimit) begin
          st_nxt    = ST_OOM;
          cnt_nxt   = CNT_W'(pages_r);
          state_nxt = S_DONE;
        end else if (!frame_used_r[fi_r[FW-1:0]]) begin
          frame_used_nxt[fi_r[FW-1:0]] = 1'b1;
          pt_we     = 1'b1;
          pt_addr   = base + AW'(pages_r);
          pt_wdata  = fi_r[FW-1:0];
          pages_nxt = pages_r + 1'b1;
          need_nxt  = need_r - 1'b1;
          fr_nxt    = FRAME_W'(fi_r);
          fi_nxt    = fi_r + 1'b1;
        end else begin
          fi_nxt = fi_r + 1'b1;
        end
      end
      S_SHR_RD: begin
        pt_addr = base + AW'(pages_r - 1'b1);
        if (need_r == '0 || pages_r == '0) begin
          cnt_nxt   = CNT_W'(pages_r);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHR_WAIT;
        end
      end
      S_SHR_WAIT: begin
        if (32'(pt_rd_r) < FRAMES) frame_used_nxt[pt_rd_r] = 1'b0;
        pages_nxt = pages_r - 1'b1;
        need_nxt  = need_r - 1'b1;
        state_nxt = S_SHR_RD;
      end
      S_NEXT_RD: begin
        if (PCW'(pi_r + 1'b1) >= pages_r || 32'(pi_r) + 1 >= PAGES_PER_PROC) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NEXT_WAIT;
        end
      end
      S_NEXT_WAIT: begin
        if (FRAME_W'(pt_rd_r) == cur_r) begin
          pt_addr   = base + AW'(pi_r + 1'b1);
          state_nxt = S_NEXT_HIT;
        end else begin
          pi_nxt    = pi_r + 1'b1;
          pt_addr   = base + AW'(pi_nxt);
          state_nxt = S_NEXT_RD;
        end
      end
      S_NEXT_HIT: begin
        pt_addr   = base + AW'(pi_r + 1'b1);
        state_nxt = S_NEXT_HIT_WAIT;
      end
      S_NEXT_HIT_WAIT: begin
        fr_nxt    = FRAME_W'(pt_rd_r);
        st_nxt    = ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_used_r <= '0;
      slot_valid_r <= '0;
      ov_r         <= 1'b0;
      page_size_r  <= PS_W'(32);
      frames_cfg_r <= FIU_W'(256);
      for (int i = 0; i < PROC_SLOTS; i++) slot_pages_r[i] <= '0;
    end else begin
      state_r      <= state_nxt;
      frame_used_r <= frame_used_nxt;
      slot_valid_r <= slot_valid_nxt;
      ov_r         <= ov_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PAGE_SIZE: page_size_r  <= cfg_data;
          REG_FRAMES:    frames_cfg_r <= cfg_data[FIU_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_FIND && state_nxt != S_FIND && act_r == ACT_CREATE
          && !hit_ok_nxt && free_ok_nxt) begin
        slot_pages_r[free_nxt] <= '0;
      end else if (state_r == S_DONE && hit_ok_r && act_r != ACT_CREATE) begin
        slot_pages_r[hit_r] <= pages_r;
      end
    end
    if (state_r == S_FIND && state_nxt != S_FIND && act_r == ACT_CREATE
        && !hit_ok_nxt && free_ok_nxt) begin
      slot_pid_r[free_nxt] <= pid_r;
    end
    act_r     <= act_nxt;
    pid_r     <= pid_nxt;
    delta_r   <= delta_nxt;
    cur_r     <= cur_nxt;
    si_r      <= si_nxt;
    hit_r     <= hit_nxt;
    hit_ok_r  <= hit_ok_nxt;
    free_r    <= free_nxt;
    free_ok_r <= free_ok_nxt;
    pages_r   <= pages_nxt;
    pi_r      <= pi_nxt;
    need_r    <= need_nxt;
    fi_r      <= fi_nxt;
    st_r      <= st_nxt;
    fr_r      <= fr_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign busy           = (state_r != S_IDLE) || ov_r;
  assign cfg_ready      = 1'b1;
  assign out_valid      = ov_r;
  assign out_status     = st_r;
  assign out_frame      = fr_r;
  assign out_page_count = cnt_r;
endmodule

// ===== rtl/pfa_checker.sv =====
module pfa_checker
  import pfa_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic [ST_W-1:0] out_status,
  input logic [CNT_W-1:0] out_page_count
);
  a_out_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("beat outside busy");
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double beat");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NO_NEXT) else $error("bad status");
  a_nopid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NO_PID || out_status == ST_NO_SLOT))
      |-> out_page_count == '0) else $error("count on failure");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after start");
endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_page_count(out_page_count)
);

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam int NFRAMES = FRAMES_DEF;
  localparam int NSLOTS  = PROC_SLOTS_DEF;
  localparam int NPAGES  = PAGES_PER_PROC_DEF;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    status_t        st;
    logic [7:0]     frame;
    logic [6:0]     cnt;
  } alloc_result_t;

  typedef struct {
    action_t                   act;
    logic [31:0]               pid;
    logic signed [20:0]        delta;
    logic [7:0]                cur;
    bit                        typed;
    alloc_result_t             res;
  } request_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [PID_W-1:0] in_pid = '0;
  logic signed [DELTA_W-1:0] in_byte_delta = '0;
  logic [FRAME_W-1:0] in_current_frame = '0;
  logic out_valid;
  logic [ST_W-1:0] out_status;
  logic [FRAME_W-1:0] out_frame;
  logic [CNT_W-1:0] out_page_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  paged_frame_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_pid(in_pid), .in_byte_delta(in_byte_delta),
    .in_current_frame(in_current_frame),
    .out_valid(out_valid), .out_status(out_status), .out_frame(out_frame),
    .out_page_count(out_page_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // allocator mirror
  int unsigned page_bytes;
  int unsigned managed_frames;
  bit          frame_taken[NFRAMES];
  bit          slot_live[NSLOTS];
  logic [31:0] slot_owner[NSLOTS];
  int unsigned slot_len[NSLOTS];
  logic [7:0]  page_map[NSLOTS*NPAGES];

  alloc_result_t pending_results[$];
  request_row_t  directed_rows[$];
  int errors = 0;
  int idle_cycles = 0;
  bit lazy_sender;
  logic [31:0] pid_pool[20];

  function automatic int lookup_slot(logic [31:0] pid);
    for (int s = 0; s < NSLOTS; s++)
      if (slot_live[s] && slot_owner[s] == pid) return s;
    return -1;
  endfunction

  function automatic int claim_frame();
    int unsigned lim;
    lim = managed_frames < NFRAMES ? managed_frames : NFRAMES;
    for (int f = 0; f < lim; f++)
      if (!frame_taken[f]) begin
        frame_taken[f] = 1'b1;
        return f;
      end
    return -1;
  endfunction

  function automatic alloc_result_t allocate(action_t act, logic [31:0] pid,
                                             logic signed [20:0] delta, logic [7:0] cur);
    alloc_result_t r;
    int s, t, f;
    int unsigned ps, need, drop, base, mag;
    r.st = ST_OK;
    r.frame = '0;
    r.cnt = '0;
    ps = page_bytes == 0 ? 1 : page_bytes;
    s = lookup_slot(pid);
    if (act == ACT_CREATE) begin
      if (s >= 0) begin
        r.cnt = 7'(slot_len[s]);
      end else begin
        for (t = 0; t < NSLOTS && slot_live[t]; t++) ;
        if (t >= NSLOTS) begin
          r.st = ST_NO_SLOT;
        end else begin
          slot_live[t] = 1'b1;
          slot_owner[t] = pid;
          slot_len[t] = 0;
        end
      end
    end else if (s < 0) begin
      r.st = ST_NO_PID;
    end else if (act == ACT_END) begin
      base = s * NPAGES;
      for (int p = 0; p < slot_len[s]; p++) frame_taken[page_map[base+p]] = 1'b0;
      slot_len[s] = 0;
      slot_live[s] = 1'b0;
    end else if (act == ACT_RESIZE) begin
      base = s * NPAGES;
      if (delta > 0) begin
        need = (int'(delta) + ps - 1) / ps;
        for (int i = 0; i < need; i++) begin
          if (slot_len[s] >= NPAGES) begin
            r.st = ST_OOM;
            break;
          end
          f = claim_frame();
          if (f < 0) begin
            r.st = ST_OOM;
            break;
          end
          page_map[base+slot_len[s]] = 8'(f);
          slot_len[s]++;
          r.frame = 8'(f);
        end
      end else if (delta < 0) begin
        mag = -int'(delta);
        drop = mag / ps;
        while (drop > 0 && slot_len[s] > 0) begin
          slot_len[s]--;
          frame_taken[page_map[base+slot_len[s]]] = 1'b0;
          drop--;
        end
      end
      r.cnt = 7'(slot_len[s]);
    end else begin
      base = s * NPAGES;
      r.st = ST_NO_NEXT;
      for (int p = 0; p + 1 < slot_len[s]; p++)
        if (page_map[base+p] == cur) begin
          r.frame = page_map[base+p+1];
          r.st = ST_OK;
          break;
        end
      r.cnt = 7'(slot_len[s]);
    end
    return r;
  endfunction

  task automatic send_request(action_t act, logic [31:0] pid, logic signed [20:0] delta,
                              logic [7:0] cur, bit typed, alloc_result_t typed_res);
    alloc_result_t r;
    int gap;
    gap = lazy_sender ? $urandom_range(16) : 0;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_action = act;
    in_pid = pid;
    in_byte_delta = delta;
    in_current_frame = cur;
    do @(posedge clk); while (busy);
    r = allocate(act, pid, delta, cur);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PAGE_SIZE) page_bytes = value & 17'h1FFFF;
    else managed_frames = value & 9'h1FF;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic void add_row(action_t act, logic [31:0] pid, logic signed [20:0] delta,
                                  logic [7:0] cur, bit typed, status_t st = ST_OK,
                                  logic [7:0] frame = 0, logic [6:0] cnt = 0);
    request_row_t row;
    row.act = act;
    row.pid = pid;
    row.delta = delta;
    row.cur = cur;
    row.typed = typed;
    row.res.st = st;
    row.res.frame = frame;
    row.res.cnt = cnt;
    directed_rows.push_back(row);
  endfunction

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected beat: status %0d frame %0d page_count %0d",
               out_status, out_frame, out_page_count);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_status);
          errors++;
        end
        if (out_frame !== e.frame) begin
          $error("frame: expected %0d, got %0d", e.frame, out_frame);
          errors++;
        end
        if (out_page_count !== e.cnt) begin
          $error("page_count: expected %0d, got %0d", e.cnt, out_page_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned ps_list[7];
    int unsigned fr_list[7];
    alloc_result_t dummy;
    action_t act;
    logic [31:0] pid;
    logic signed [20:0] delta;
    logic [7:0] cur;
    int s, k, unit;

    ps_list = '{1, 65536, 0, 16, 7, 131071, 64};
    fr_list = '{1, 256, 511, 8, 64, 0, 300};
    page_bytes = 32;
    managed_frames = 256;
    foreach (frame_taken[i]) frame_taken[i] = 1'b0;
    foreach (slot_live[i]) begin
      slot_live[i] = 1'b0;
      slot_len[i] = 0;
    end
    pid_pool[0] = 32'h0;
    pid_pool[1] = 32'hFFFF_FFFF;
    pid_pool[2] = 32'h8000_0000;
    pid_pool[3] = 32'h5555_5555;
    pid_pool[4] = 32'hAAAA_AAAA;
    for (int i = 5; i < 20; i++) pid_pool[i] = $urandom();
    dummy = '{ST_OK, 8'd0, 7'd0};
    lazy_sender = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_row(ACT_NEXT,   32'd5, 21'sd0, 8'd0, 1'b1, ST_NO_PID);
    add_row(ACT_END,    32'd5, 21'sd0, 8'd0, 1'b1, ST_NO_PID);
    add_row(ACT_RESIZE, 32'd5, 21'sd64, 8'd0, 1'b1, ST_NO_PID);
    add_row(ACT_CREATE, 32'd0, 21'sd0, 8'd0, 1'b1, ST_OK);
    add_row(ACT_CREATE, 32'd0, 21'sd0, 8'd0, 1'b1, ST_OK);
    add_row(ACT_RESIZE, 32'd0, 21'sd1, 8'd0, 1'b1, ST_OK, 8'd0, 7'd1);
    add_row(ACT_RESIZE, 32'd0, 21'sd0, 8'd0, 1'b1, ST_OK, 8'd0, 7'd1);
    add_row(ACT_RESIZE, 32'd0, 21'sd64, 8'd0, 1'b0);
    add_row(ACT_NEXT,   32'd0, 21'sd0, 8'd0, 1'b0);
    add_row(ACT_NEXT,   32'd0, 21'sd0, 8'd2, 1'b1, ST_NO_NEXT, 8'd0, 7'd3);
    add_row(ACT_NEXT,   32'd0, 21'sd0, 8'd255, 1'b1, ST_NO_NEXT, 8'd0, 7'd3);
    add_row(ACT_CREATE, 32'hFFFF_FFFF, 21'sd0, 8'd0, 1'b1, ST_OK);
    add_row(ACT_RESIZE, 32'hFFFF_FFFF, 21'sd1048575, 8'd0, 1'b0);
    add_row(ACT_NEXT,   32'hFFFF_FFFF, 21'sd0, 8'd65, 1'b0);
    add_row(ACT_RESIZE, 32'd0, -21'sd1048576, 8'd0, 1'b1, ST_OK, 8'd0, 7'd0);
    add_row(ACT_RESIZE, 32'hFFFF_FFFF, -21'sd31, 8'd0, 1'b1, ST_OK, 8'd0, 7'd64);
    add_row(ACT_RESIZE, 32'hFFFF_FFFF, -21'sd33, 8'd0, 1'b0);
    add_row(ACT_END,    32'hFFFF_FFFF, 21'sd0, 8'd0, 1'b1, ST_OK);
    add_row(ACT_END,    32'hFFFF_FFFF, 21'sd0, 8'd0, 1'b1, ST_NO_PID);
    add_row(ACT_END,    32'd0, 21'sd0, 8'd0, 1'b1, ST_OK);
    foreach (directed_rows[i])
      send_request(directed_rows[i].act, directed_rows[i].pid, directed_rows[i].delta,
                   directed_rows[i].cur, directed_rows[i].typed, directed_rows[i].res);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_PAGE_SIZE, ps_list[ph]);
      write_reg(REG_FRAMES, fr_list[ph]);
      lazy_sender = (ph % 2) == 1;
      unit = ps_list[ph] == 0 ? 1 : (ps_list[ph] > 4096 ? ps_list[ph] : ps_list[ph]);
      for (int n = 0; n < 270; n++) begin
        if (n % 60 == 0) lazy_sender = $urandom_range(1);
        k = $urandom_range(99);
        pid = k < 3 ? $urandom() : pid_pool[$urandom_range(k < 50 ? 19 : 7)];
        k = $urandom_range(99);
        act = k < 20 ? ACT_CREATE : k < 30 ? ACT_END : k < 75 ? ACT_RESIZE : ACT_NEXT;
        k = $urandom_range(99);
        if (k < 10) delta = 21'($urandom());
        else if (k < 65) delta = 21'($urandom_range(4 * (unit > 262143 ? 262143 : unit)));
        else if (k < 70) delta = 0;
        else delta = -$signed(21'($urandom_range(4 * (unit > 262143 ? 262143 : unit))));
        cur = 8'($urandom());
        s = lookup_slot(pid);
        if (s >= 0 && slot_len[s] > 0 && $urandom_range(3) != 0)
          cur = page_map[s*NPAGES + $urandom_range(slot_len[s] - 1)];
        send_request(act, pid, delta, cur, 1'b0, dummy);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pfa_pkg.sv
rtl/pfa_div.sv
rtl/paged_frame_allocator.sv
rtl/pfa_checker.sv
verif/testbench.sv
